// File: hw/rtl/aapr_pkg.sv
package aapr_pkg;

  localparam int COORD_W             = 32;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int SCALE_FRAC_BITS     = 15;
  localparam int Q_FRAC              = 30;
  localparam int ANG_W               = 38;
  localparam int CORDIC_STEPS        = 30;

  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 38'sd6746518852;
  localparam logic signed [ANG_W-1:0] PI_Q30      = 38'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 38'sd1686629713;
  localparam logic signed [33:0]      ONE_Q30     = 34'sd1073741824;
  localparam logic signed [33:0]      GAIN_INV    = 34'sd652032874;

  typedef enum logic [2:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_START_Z = 3'd2,
    CFG_END_X   = 3'd3,
    CFG_END_Y   = 3'd4,
    CFG_END_Z   = 3'd5,
    CFG_ANGLE   = 3'd6,
    CFG_SCALE   = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_DIFF, ST_NORM, ST_SQ, ST_SQRT, ST_DIV, ST_ANG, ST_MOD, ST_WRAP,
    ST_FOLD, ST_CORD, ST_CS, ST_MQ, ST_MAT, ST_RQ, ST_IDLE
  } setup_state_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
    logic               degenerate_axis;
  } out_item_t;

  // matrix, translation and status handed from setup to the point pipeline
  typedef struct packed {
    logic [8:0][31:0] rm;
    logic [2:0][35:0] tq;
    logic             degen;
    logic             ready;
  } aapr_coef_t;

  function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sh3243F6A8;
      5'd1:  v = 34'sh1DAC6705;
      5'd2:  v = 34'sh0FADBAFC;
      5'd3:  v = 34'sh07F56EA6;
      5'd4:  v = 34'sh03FEAB76;
      5'd5:  v = 34'sh01FFD55B;
      5'd6:  v = 34'sh00FFFAAA;
      5'd7:  v = 34'sh007FFF55;
      5'd8:  v = 34'sh003FFFEA;
      5'd9:  v = 34'sh001FFFFD;
      5'd10: v = 34'sh000FFFFF;
      5'd11: v = 34'sh0007FFFF;
      5'd12: v = 34'sh0003FFFF;
      5'd13: v = 34'sh0001FFFF;
      5'd14: v = 34'sh0000FFFF;
      5'd15: v = 34'sh00007FFF;
      5'd16: v = 34'sh00003FFF;
      5'd17: v = 34'sh00001FFF;
      5'd18: v = 34'sh00000FFF;
      5'd19: v = 34'sh000007FF;
      5'd20: v = 34'sh000003FF;
      5'd21: v = 34'sh000001FF;
      5'd22: v = 34'sh000000FF;
      5'd23: v = 34'sh0000007F;
      5'd24: v = 34'sh0000003F;
      5'd25: v = 34'sh0000001F;
      5'd26: v = 34'sh0000000F;
      5'd27: v = 34'sh00000008;
      5'd28: v = 34'sh00000004;
      5'd29: v = 34'sh00000002;
      default: v = 34'sh0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/aapr_stream_if.sv
interface aapr_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// File: hw/rtl/aapr_setup.sv
module aapr_setup
  import aapr_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output aapr_coef_t  coef
);

  localparam int ANGLE_SHIFT = Q_FRAC - (ANGLE_FRAC_BITS + SCALE_FRAC_BITS);
  localparam logic [5:0] DIV_LAST = 6'd60;

  // product slots of the matrix phase
  localparam logic [3:0] M_TX = 4'd0, M_TY = 4'd1, M_TZ = 4'd2, M_XX = 4'd3;
  localparam logic [3:0] M_XY = 4'd4, M_XZ = 4'd5, M_YY = 4'd6, M_YZ = 4'd7;
  localparam logic [3:0] M_ZZ = 4'd8, M_ZS = 4'd9, M_YS = 4'd10, M_XS = 4'd11;

  logic signed [31:0] start_r [3];
  logic signed [31:0] end_r [3];
  logic signed [15:0] inc_r;
  logic [15:0]        scl_r;

  setup_state_t st_r, st_nxt;
  logic [5:0]  k_r;
  logic [1:0]  comp_r;

  logic [32:0] mag_r [3];
  logic        negd_r [3];
  logic        degen_r;
  logic [62:0] sq_n_r, sq_res_r, sq_bit_r;
  logic [60:0] dvd_r;
  logic [30:0] rem_r;
  logic [30:0] quo_r;
  logic signed [31:0] u_r [3];
  logic signed [ANG_W-1:0] ang_r;
  logic        fneg_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic signed [31:0] c_r, s_r;
  logic signed [33:0] mres_r [12];
  logic signed [31:0] rm_r [9];
  logic signed [65:0] acc_r;
  logic signed [35:0] tq_r [3];

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_r;

  logic signed [32:0] dif [3];
  logic [32:0] dmag [3];
  logic        d_zero;
  logic [32:0] mmax;
  logic [62:0] sq_trial;
  logic [31:0] rem2;
  logic        div_ge;
  logic [30:0] qfin;
  logic signed [32:0] wprod;
  logic signed [ANG_W-1:0] ang_fold;
  logic        fold_neg;
  logic signed [33:0] t_q30;
  logic signed [33:0] mq_rnd;
  logic [3:0]  jidx;
  logic [1:0]  jcol, jrow;
  logic signed [65:0] acc_new;

  function automatic logic [1:0] col3(input logic [3:0] v);
    case (v)
      4'd0, 4'd3, 4'd6: col3 = 2'd0;
      4'd1, 4'd4, 4'd7: col3 = 2'd1;
      default:          col3 = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] row3(input logic [3:0] v);
    case (v)
      4'd0, 4'd1, 4'd2: row3 = 2'd0;
      4'd3, 4'd4, 4'd5: row3 = 2'd1;
      default:          row3 = 2'd2;
    endcase
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [34:0] v);
    if (v > 35'(ONE_Q30))       clamp_q30 = 32'(ONE_Q30);
    else if (v < -35'(ONE_Q30)) clamp_q30 = -32'(ONE_Q30);
    else                        clamp_q30 = v[31:0];
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        start_r[i] <= '0;
        end_r[i]   <= '0;
      end
      inc_r <= '0;
      scl_r <= 16'd32768;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_START_X: start_r[0] <= cfg_wdata;
        CFG_START_Y: start_r[1] <= cfg_wdata;
        CFG_START_Z: start_r[2] <= cfg_wdata;
        CFG_END_X:   end_r[0]   <= cfg_wdata;
        CFG_END_Y:   end_r[1]   <= cfg_wdata;
        CFG_END_Z:   end_r[2]   <= cfg_wdata;
        CFG_ANGLE:   inc_r      <= cfg_wdata[15:0];
        CFG_SCALE:   scl_r      <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // shared datapath terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i]  = 33'(end_r[i]) - 33'(start_r[i]);
      dmag[i] = dif[i][32] ? 33'(-dif[i]) : 33'(dif[i]);
    end
    d_zero = (dmag[0] == '0) && (dmag[1] == '0) && (dmag[2] == '0);
    mmax = mag_r[0];
    if (mag_r[1] > mmax) mmax = mag_r[1];
    if (mag_r[2] > mmax) mmax = mag_r[2];

    sq_trial = sq_res_r + sq_bit_r;

    rem2   = {rem_r, dvd_r[60]};
    div_ge = rem2 >= sq_res_r[31:0];
    qfin   = {quo_r[29:0], div_ge};

    wprod = 33'(inc_r) * $signed({17'b0, scl_r});

    ang_fold = ang_r;
    fold_neg = 1'b0;
    if (ang_r > HALF_PI_Q30) begin
      ang_fold = ang_r - PI_Q30;
      fold_neg = 1'b1;
    end else if (ang_r < -HALF_PI_Q30) begin
      ang_fold = ang_r + PI_Q30;
      fold_neg = 1'b1;
    end

    t_q30  = ONE_Q30 - 34'(c_r);
    mq_rnd = 34'((prod_r + 68'sd536870912) >>> Q_FRAC);

    jidx    = 4'(k_r - 6'd1);
    jcol    = col3(jidx);
    jrow    = row3(jidx);
    acc_new = ((jcol == 2'd0) ? 66'sd0 : acc_r) + 66'(prod_r);
  end

  // operand select of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      ST_SQ: begin
        if (k_r < 6'd3) begin
          mul_a = $signed({1'b0, mag_r[k_r[1:0]]});
          mul_b = $signed({1'b0, mag_r[k_r[1:0]]});
        end
      end
      ST_MQ: begin
        case (k_r[3:0])
          M_TX: begin mul_a = t_q30;        mul_b = 34'(u_r[0]); end
          M_TY: begin mul_a = t_q30;        mul_b = 34'(u_r[1]); end
          M_TZ: begin mul_a = t_q30;        mul_b = 34'(u_r[2]); end
          M_XX: begin mul_a = mres_r[M_TX]; mul_b = 34'(u_r[0]); end
          M_XY: begin mul_a = mres_r[M_TX]; mul_b = 34'(u_r[1]); end
          M_XZ: begin mul_a = mres_r[M_TX]; mul_b = 34'(u_r[2]); end
          M_YY: begin mul_a = mres_r[M_TY]; mul_b = 34'(u_r[1]); end
          M_YZ: begin mul_a = mres_r[M_TY]; mul_b = 34'(u_r[2]); end
          M_ZZ: begin mul_a = mres_r[M_TZ]; mul_b = 34'(u_r[2]); end
          M_ZS: begin mul_a = 34'(u_r[2]);  mul_b = 34'(s_r);    end
          M_YS: begin mul_a = 34'(u_r[1]);  mul_b = 34'(s_r);    end
          M_XS: begin mul_a = 34'(u_r[0]);  mul_b = 34'(s_r);    end
          default: ;
        endcase
      end
      ST_RQ: begin
        if (k_r < 6'd9) begin
          mul_a = 34'(rm_r[k_r[3:0]]);
          mul_b = 34'(end_r[col3(k_r[3:0])]);
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_DIFF: st_nxt = d_zero ? ST_IDLE : ST_NORM;
      ST_NORM: begin
        if (mmax >= 33'd536870912 && mmax < 33'd1073741824) st_nxt = ST_SQ;
      end
      ST_SQ:   if (k_r == 6'd3) st_nxt = ST_SQRT;
      ST_SQRT: if (sq_bit_r[0]) st_nxt = ST_DIV;
      ST_DIV:  if (k_r == DIV_LAST && comp_r == 2'd2) st_nxt = ST_ANG;
      ST_ANG:  st_nxt = ST_MOD;
      ST_MOD:  if (ang_r >= 0 && ang_r < TWO_PI_Q30) st_nxt = ST_WRAP;
      ST_WRAP: st_nxt = ST_FOLD;
      ST_FOLD: st_nxt = ST_CORD;
      ST_CORD: if (k_r == 6'(CORDIC_STEPS - 1)) st_nxt = ST_CS;
      ST_CS:   st_nxt = ST_MQ;
      ST_MQ:   if (k_r == 6'd12) st_nxt = ST_MAT;
      ST_MAT:  st_nxt = ST_RQ;
      ST_RQ:   if (k_r == 6'd9) st_nxt = ST_IDLE;
      ST_IDLE: st_nxt = ST_IDLE;
      default: st_nxt = ST_DIFF;
    endcase
    if (cfg_we) st_nxt = ST_DIFF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_DIFF;
      k_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_nxt != st_r || cfg_we) k_r <= '0;
      else if (st_r == ST_DIV && k_r == DIV_LAST) k_r <= '0;
      else k_r <= k_r + 6'd1;
    end
  end

  // setup datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (st_r)
      ST_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          mag_r[i]  <= dmag[i];
          negd_r[i] <= dif[i][32];
        end
        degen_r <= d_zero;
      end
      ST_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (mmax < 33'd536870912)        mag_r[i] <= {mag_r[i][31:0], 1'b0};
          else if (mmax >= 33'd1073741824) mag_r[i] <= {1'b0, mag_r[i][32:1]};
        end
      end
      ST_SQ: begin
        if (k_r == 6'd1)      sq_n_r <= 63'(prod_r[61:0]);
        else if (k_r != 6'd0) sq_n_r <= sq_n_r + 63'(prod_r[61:0]);
        sq_res_r <= '0;
        sq_bit_r <= 63'(1) << 62;
      end
      ST_SQRT: begin
        if (sq_n_r >= sq_trial) begin
          sq_n_r   <= sq_n_r - sq_trial;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
        comp_r   <= '0;
        rem_r    <= '0;
        dvd_r    <= {1'b0, mag_r[0][29:0], 30'b0};
      end
      ST_DIV: begin
        quo_r <= qfin;
        if (k_r == DIV_LAST)
          u_r[comp_r] <= negd_r[comp_r] ? -$signed({1'b0, qfin}) : $signed({1'b0, qfin});
        if (k_r == DIV_LAST && comp_r != 2'd2) begin
          comp_r <= comp_r + 2'd1;
          rem_r  <= '0;
          dvd_r  <= {1'b0, mag_r[comp_r + 2'd1][29:0], 30'b0};
        end else begin
          rem_r <= div_ge ? 31'(rem2 - sq_res_r[31:0]) : rem2[30:0];
          dvd_r <= {dvd_r[59:0], 1'b0};
        end
      end
      ST_ANG: ang_r <= ANG_W'(wprod) <<< ANGLE_SHIFT;
      ST_MOD: begin
        if (ang_r < 0)                ang_r <= ang_r + TWO_PI_Q30;
        else if (ang_r >= TWO_PI_Q30) ang_r <= ang_r - TWO_PI_Q30;
      end
      ST_WRAP: if (ang_r > PI_Q30) ang_r <= ang_r - TWO_PI_Q30;
      ST_FOLD: begin
        fneg_r <= fold_neg;
        cz_r   <= 34'(ang_fold);
        cx_r   <= GAIN_INV;
        cy_r   <= '0;
      end
      ST_CORD: begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - (cy_r >>> k_r[4:0]);
          cy_r <= cy_r + (cx_r >>> k_r[4:0]);
          cz_r <= cz_r - atan_lut(k_r[4:0]);
        end else begin
          cx_r <= cx_r + (cy_r >>> k_r[4:0]);
          cy_r <= cy_r - (cx_r >>> k_r[4:0]);
          cz_r <= cz_r + atan_lut(k_r[4:0]);
        end
      end
      ST_CS: begin
        c_r <= clamp_q30(fneg_r ? -35'(cx_r) : 35'(cx_r));
        s_r <= clamp_q30(fneg_r ? -35'(cy_r) : 35'(cy_r));
      end
      ST_MQ: if (k_r != 6'd0) mres_r[4'(k_r - 6'd1)] <= mq_rnd;
      ST_MAT: begin
        rm_r[0] <= clamp_q30(35'(mres_r[M_XX]) + 35'(c_r));
        rm_r[1] <= clamp_q30(35'(mres_r[M_XY]) - 35'(mres_r[M_ZS]));
        rm_r[2] <= clamp_q30(35'(mres_r[M_XZ]) + 35'(mres_r[M_YS]));
        rm_r[3] <= clamp_q30(35'(mres_r[M_XY]) + 35'(mres_r[M_ZS]));
        rm_r[4] <= clamp_q30(35'(mres_r[M_YY]) + 35'(c_r));
        rm_r[5] <= clamp_q30(35'(mres_r[M_YZ]) - 35'(mres_r[M_XS]));
        rm_r[6] <= clamp_q30(35'(mres_r[M_XZ]) - 35'(mres_r[M_YS]));
        rm_r[7] <= clamp_q30(35'(mres_r[M_YZ]) + 35'(mres_r[M_XS]));
        rm_r[8] <= clamp_q30(35'(mres_r[M_ZZ]) + 35'(c_r));
      end
      ST_RQ: begin
        if (k_r != 6'd0) begin
          acc_r <= acc_new;
          if (jcol == 2'd2)
            tq_r[jrow] <= 36'(end_r[jrow]) - 36'((acc_new + 66'sd536870912) >>> Q_FRAC);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 9; i++) coef.rm[i] = rm_r[i];
    for (int i = 0; i < 3; i++) coef.tq[i] = tq_r[i];
    coef.degen = degen_r;
    coef.ready = (st_r == ST_IDLE);
  end

endmodule

// File: hw/rtl/axis_angle_point_rotator.sv
// Channel  | Dir | Payload                                         | Handshake
// in_ch    | in  | point_x, point_y, point_z (Q16.16)              | valid/ready
// out_ch   | out | rotated_x/y/z (Q16.16, saturated), degen. flag  | valid/ready
// cfg_*    | in  | index 0..7, 32-bit data                         | write enable only
//
// One point per cycle unless out_ch stalls; each point is registered in stages 1 to 3.
// After reset and after every config write the setup sequencer (one shared
// multiplier, bit-serial sqrt/divide, 30-step CORDIC) rebuilds the matrix, and
// in_ch.ready stays low until it is done; a zero-length axis skips the work.
// Reset is synchronous; registers come back to their reset values.
// Each pipe stage moves when the one after it is empty or moving, so an
// output stall fills bubbles first and then holds every stage.
module axis_angle_point_rotator
  import aapr_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  aapr_stream_if.sink   in_ch,
  aapr_stream_if.source out_ch
);

  aapr_coef_t coef;

  // stage 1: nine lane products, stage 2: row sums plus translation,
  // stage 3: saturate into the output register
  logic               s1_v_r;
  logic signed [63:0] s1_prod_r [9];
  in_item_t           s1_p_r;
  logic               s2_v_r;
  logic signed [36:0] s2_val_r [3];
  logic               out_v_r;
  out_item_t          out_r;

  logic               en3, en2, en1, take;
  in_item_t           in_p;
  logic signed [31:0] pv [3];
  logic signed [31:0] p1 [3];
  logic signed [36:0] s2_nxt [3];
  logic signed [31:0] sat [3];

  aapr_setup #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  assign en3  = !out_v_r || out_ch.ready;
  assign en2  = !s2_v_r || en3;
  assign en1  = !s1_v_r || en2;
  assign in_ch.ready = coef.ready && en1;
  assign take = in_ch.valid && in_ch.ready;
  assign in_p = in_ch.payload;

  always_comb begin
    pv[0] = in_p.point_x;
    pv[1] = in_p.point_y;
    pv[2] = in_p.point_z;
    p1[0] = s1_p_r.point_x;
    p1[1] = s1_p_r.point_y;
    p1[2] = s1_p_r.point_z;
    for (int i = 0; i < 3; i++) begin
      // zero-length axis: point goes through untouched
      if (coef.degen)
        s2_nxt[i] = 37'(p1[i]);
      else
        s2_nxt[i] = 37'((66'(s1_prod_r[3*i]) + 66'(s1_prod_r[3*i+1])
                        + 66'(s1_prod_r[3*i+2]) + 66'sd536870912) >>> Q_FRAC)
                  + 37'($signed(coef.tq[i]));
      if (s2_val_r[i] > 37'sd2147483647)       sat[i] = 32'h7FFF_FFFF;
      else if (s2_val_r[i] < -37'sd2147483648) sat[i] = 32'h8000_0000;
      else                                     sat[i] = s2_val_r[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r  <= take;
      if (en2) s2_v_r  <= s1_v_r;
      if (en3) out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && take) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          s1_prod_r[3*i+j] <= $signed(coef.rm[3*i+j]) * pv[j];
      s1_p_r <= in_p;
    end
    if (en2 && s1_v_r) begin
      for (int i = 0; i < 3; i++) s2_val_r[i] <= s2_nxt[i];
    end
    if (en3 && s2_v_r) begin
      out_r.rotated_x       <= sat[0];
      out_r.rotated_y       <= sat[1];
      out_r.rotated_z       <= sat[2];
      out_r.degenerate_axis <= coef.degen;
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.payload = out_r;

`ifndef SYNTHESIS
  a_cfg_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ch.ready)
    else $error("input open right after a config write");

  a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && out_v_r && !out_ch.ready) |=> s2_v_r)
    else $error("stage 2 item lost under output stall");

  a_degen_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.payload.degenerate_axis) |-> coef.degen)
    else $error("degenerate flag without zero-length axis");
`endif

endmodule

// File: tb/testbench.sv
module testbench;
  import aapr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Fixed-point landmarks of the rotation math
  localparam longint ONE_Q30   = 64'sd1073741824;
  localparam longint HALF_Q30  = 64'sd536870912;
  localparam longint TWO_PI    = 64'sd6746518852;
  localparam longint PI        = 64'sd3373259426;
  localparam longint HALF_PI   = 64'sd1686629713;
  localparam longint CORDIC_K  = 64'sd652032874;
  localparam int     STALL_MAX = 4000;  // cycles without any transaction

  // pi/2 and pi in Q3.13, with unit scale (1.0 in Q1.15)
  localparam logic [15:0] ANG_HALF_PI = 16'd12868;
  localparam logic [15:0] ANG_PI      = 16'd25736;
  localparam logic [15:0] SCALE_ONE   = 16'd32768;

  // arctangent of 2^-i in Q30 radians
  localparam longint ATAN_Q30 [30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  aapr_stream_if #(.payload_t(in_item_t))  in_ch();
  aapr_stream_if #(.payload_t(out_item_t)) out_ch();

  axis_angle_point_rotator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow of the configuration registers, as the block should hold them
  logic signed [31:0] axis_start [3];
  logic signed [31:0] axis_end [3];
  logic signed [15:0] angle_inc;
  logic [15:0]        angle_scale;

  out_item_t   rotated_q[$];   // rotated points still owed by the block
  int          fail_count;
  int          quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic longint mul_q30(longint a, longint b);
    return (a * b + HALF_Q30) >>> 30;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > ONE_Q30) return ONE_Q30;
    if (v < -ONE_Q30) return -ONE_Q30;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bit_w;
    root  = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (n >= root + bit_w) begin
        n    = n - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  // CORDIC sine/cosine of increment*scale, after reduction to [-pi/2, pi/2]
  function automatic void angle_sin_cos(output longint sin_q, output longint cos_q);
    longint ang, cx, cy, xs, ys;
    bit     flip;
    ang  = (longint'(angle_inc) * longint'(angle_scale) * 4) % TWO_PI;
    flip = 1'b0;
    if (ang < 0) ang = ang + TWO_PI;
    if (ang > PI) ang = ang - TWO_PI;
    if (ang > HALF_PI) begin
      ang  = ang - PI;
      flip = 1'b1;
    end else if (ang < -HALF_PI) begin
      ang  = ang + PI;
      flip = 1'b1;
    end
    cx = CORDIC_K;
    cy = 0;
    for (int i = 0; i < 30; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (ang >= 0) begin
        cx  = cx - ys;
        cy  = cy + xs;
        ang = ang - ATAN_Q30[i];
      end else begin
        cx  = cx + ys;
        cy  = cy - xs;
        ang = ang + ATAN_Q30[i];
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    cos_q = clamp_unit(cx);
    sin_q = clamp_unit(cy);
  endfunction

  function automatic out_item_t rotate_point(in_item_t pt);
    longint             p[3], q[3], d[3], u[3], rm[3][3];
    longint unsigned    mag[3], mx, sq, len;
    longint             s, c, t, tx, ty, tz, ap, aq, v;
    logic signed [31:0] res[3];
    out_item_t          r;
    p[0] = pt.point_x;
    p[1] = pt.point_y;
    p[2] = pt.point_z;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      q[i]   = axis_end[i];
      d[i]   = q[i] - longint'(axis_start[i]);
      mag[i] = (d[i] < 0) ? -d[i] : d[i];
      if (mag[i] > mx) mx = mag[i];
    end
    // zero-length axis: the point passes through, flagged
    if (mx == 0) begin
      r = '{pt.point_x, pt.point_y, pt.point_z, 1'b1};
      return r;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) sq = sq + mag[i] * mag[i];
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      v    = longint'((mag[i] << 30) / len);
      u[i] = (d[i] < 0) ? -v : v;
    end

    angle_sin_cos(s, c);
    t  = ONE_Q30 - c;
    tx = mul_q30(t, u[0]);
    ty = mul_q30(t, u[1]);
    tz = mul_q30(t, u[2]);
    rm[0][0] = mul_q30(tx, u[0]) + c;
    rm[0][1] = mul_q30(tx, u[1]) - mul_q30(u[2], s);
    rm[0][2] = mul_q30(tx, u[2]) + mul_q30(u[1], s);
    rm[1][0] = mul_q30(tx, u[1]) + mul_q30(u[2], s);
    rm[1][1] = mul_q30(ty, u[1]) + c;
    rm[1][2] = mul_q30(ty, u[2]) - mul_q30(u[0], s);
    rm[2][0] = mul_q30(tx, u[2]) - mul_q30(u[1], s);
    rm[2][1] = mul_q30(ty, u[2]) + mul_q30(u[0], s);
    rm[2][2] = mul_q30(tz, u[2]) + c;

    // R*p - R*Q + Q, the two row sums rounded separately, then saturated
    for (int i = 0; i < 3; i++) begin
      ap = 0;
      aq = 0;
      for (int j = 0; j < 3; j++) begin
        rm[i][j] = clamp_unit(rm[i][j]);
        ap = ap + rm[i][j] * p[j];
        aq = aq + rm[i][j] * q[j];
      end
      v = ((ap + HALF_Q30) >>> 30) - ((aq + HALF_Q30) >>> 30) + q[i];
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      res[i] = v[31:0];
    end
    r = '{res[0], res[1], res[2], 1'b0};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and watchdog, sampled mid-cycle where everything is settled
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_item_t want;
    out_item_t got;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else if (rst_n) begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_MAX) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_MAX);
      $display("simulation failed");
      $finish;
    end
    if (out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (rotated_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d degen=%0b", $time,
                 got.rotated_x, got.rotated_y, got.rotated_z, got.degenerate_axis);
        fail_count++;
      end else begin
        want = rotated_q.pop_front();
        if (got.rotated_x !== want.rotated_x) begin
          $display("%0t: rotated_x expected %0d actual %0d", $time,
                   want.rotated_x, got.rotated_x);
          fail_count++;
        end
        if (got.rotated_y !== want.rotated_y) begin
          $display("%0t: rotated_y expected %0d actual %0d", $time,
                   want.rotated_y, got.rotated_y);
          fail_count++;
        end
        if (got.rotated_z !== want.rotated_z) begin
          $display("%0t: rotated_z expected %0d actual %0d", $time,
                   want.rotated_z, got.rotated_z);
          fail_count++;
        end
        if (got.degenerate_axis !== want.degenerate_axis) begin
          $display("%0t: degenerate_axis expected %0b actual %0b", $time,
                   want.degenerate_axis, got.degenerate_axis);
          fail_count++;
        end
      end
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One input transaction; valid is left high so back-to-back points stream
  task automatic send_point(in_item_t pt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= pt;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    rotated_q = {rotated_q, rotate_point(pt)};
    @(posedge clk);
  endtask

  // Stop sending and let every owed result come out
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Full register load; only called with the block drained.
  // Upper bits of the 16-bit registers carry junk that must be ignored.
  task automatic load_axis(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                           logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                           logic [15:0] inc, logic [15:0] scl);
    logic [31:0] vals[8];
    cfg_reg_t    idx;
    vals = '{sx, sy, sz, ex, ey, ez, {16'($urandom_range(65535)), inc},
             {16'($urandom_range(65535)), scl}};
    idx = CFG_START_X;
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= vals[i];
      @(posedge clk);
      idx = cfg_reg_t'(idx + 3'd1);
    end
    cfg_we <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      axis_start[i] = vals[i];
      axis_end[i]   = vals[3 + i];
    end
    angle_inc   = inc;
    angle_scale = scl;
  endtask

  // Mostly modest coordinates, some full range and some extremes
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2, 3:    return $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
      default: return $urandom_range(32'h0FFF_FFFF) - 32'h0800_0000;
    endcase
  endfunction

  function automatic in_item_t rand_point();
    in_item_t pt;
    pt.point_x = rand_coord();
    pt.point_y = rand_coord();
    pt.point_z = rand_coord();
    return pt;
  endfunction

  task automatic load_random_axis();
    logic [31:0] sx, sy, sz;
    sx = rand_coord();
    sy = rand_coord();
    sz = rand_coord();
    // now and then a zero-length axis
    if ($urandom_range(7) == 0) begin
      load_axis(sx, sy, sz, sx, sy, sz, 16'($urandom()), 16'($urandom()));
    end else begin
      load_axis(sx, sy, sz, rand_coord(), rand_coord(), rand_coord(),
                16'($urandom()), $urandom_range(3) == 0 ? SCALE_ONE : 16'($urandom()));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers at reset values: zero axis, so points pass through flagged
  task automatic test_reset_state();
    for (int i = 0; i < 3; i++) begin
      axis_start[i] = '0;
      axis_end[i]   = '0;
    end
    angle_inc   = '0;
    angle_scale = SCALE_ONE;
    send_point('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000});
    send_point('{32'sh0, 32'sh0, 32'sh0});
    drain();
  endtask

  // Largest positive angle at the largest scale on a skewed axis
  task automatic load_axis_keep_check();
    drain();
    load_axis(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000,
              32'h0004_0000, 32'h0000_8000, 16'h7FFF, 16'hFFFF);
    send_point('{32'sh0, 32'sh0, 32'sh0});
    send_point('{32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0});
    drain();
  endtask

  // Quarter and half turns about axes, saturation, extreme angle and scale
  task automatic test_directed_axes();
    // z axis through the origin, quarter turn
    load_axis(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, ANG_HALF_PI, SCALE_ONE);
    send_point('{32'sh0001_0000, 32'sh0, 32'sh0});
    send_point('{32'sh0, 32'sh0002_0000, 32'sh0003_0000});
    send_point('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    send_point('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    drain();
    // half turn about an x-parallel line offset from the origin
    load_axis(32'h0010_0000, 32'h0005_0000, 32'h0, 32'h0020_0000, 32'h0005_0000,
              32'h0, ANG_PI, SCALE_ONE);
    send_point('{32'sh0, 32'sh0, 32'sh0});
    send_point('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
    send_point('{32'sh1234_5678, 32'shFEDC_BA98, 32'sh0000_FFFF});
    drain();
    // widest axis difference and the most negative angle at the largest scale
    load_axis(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'hFFFF);
    send_point('{32'sh7FFF_FFFF, 32'sh0, 32'sh8000_0000});
    send_point('{32'sh0001_0000, 32'shFFFF_0000, 32'sh0});
    send_point('{32'shFFFF_FFFF, 32'shAAAA_AAAA, 32'sh5555_5555});
    drain();
    // smallest nonzero axis, largest positive angle, zero scale
    load_axis(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 16'h7FFF, 16'h0);
    send_point('{32'sh0010_0000, 32'sh0020_0000, 32'sh0030_0000});
    load_axis_keep_check();
    // explicit degenerate axis away from the origin
    load_axis(32'h0003_0000, 32'hFFFD_0000, 32'h7FFF_FFFF, 32'h0003_0000,
              32'hFFFD_0000, 32'h7FFF_FFFF, ANG_HALF_PI, SCALE_ONE);
    send_point('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0001});
    drain();
  endtask

  // Random axes and points under one idling pattern
  task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                   int n_points, bit hold_off);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < 4; k++) begin
      load_random_axis();
      for (int i = 0; i < n_points / 4; i++) begin
        send_point(rand_point());
        // sender holds off until the pipe is empty, then resumes
        if (hold_off && i == n_points / 8) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (rotated_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_START_X;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    out_ch.ready   = 1'b0;
    fail_count     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed_axes();
    test_random_phase(0, 0, 200, 1'b0);
    test_random_phase(71, 0, 200, 1'b1);
    test_random_phase(0, 71, 200, 1'b0);
    test_random_phase(20, 20, 200, 1'b1);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
